// ----- design/pskf_pkg.sv -----
// Shared types, constants and helpers for the per-cell scalar Kalman fusion block.
// Used by the front, back and top modules under design/; depends on nothing.
package pskf_pkg;

    // Channel widths
    localparam int IN_DATA_W  = 56;   // 54 field bits, padded to whole bytes
    localparam int OUT_DATA_W = 32;
    localparam int CFG_W      = 16;

    // Configuration register indexes
    localparam logic REG_PROCESS_VAR = 1'b0;
    localparam logic REG_MEAS_VAR    = 1'b1;

    localparam logic [CFG_W-1:0] PROCESS_VAR_RST = 16'd655;
    localparam logic [CFG_W-1:0] MEAS_VAR_RST    = 16'd1638;

    // Q1.15
    localparam logic [15:0] Q15_ONE  = 16'd32768;
    localparam logic [15:0] Q15_HALF = 16'd16384;

    // Fused measurement, Q1.15, may lie outside 0..1
    localparam int MEAS_W = 17;
    typedef logic signed [MEAS_W-1:0] meas_t;

    // Measurement numerator: 163840*(10000-m) + 30000*q + 20000*d + 50000,
    // biased by 11000*100000 so it never goes negative.
    localparam int ACC_W = 33;
    localparam logic [ACC_W-1:0] MEAS_OFFSET = 33'd2738450000;
    localparam logic [ACC_W-1:0] MOIST_GAIN  = 33'd163840;
    localparam logic [ACC_W-1:0] QUAL_GAIN   = 33'd30000;
    localparam logic [ACC_W-1:0] DEMAND_GAIN = 33'd20000;
    localparam meas_t            MEAS_BIAS   = 17'sd11000;

    // floor(n / 100000) = ((n >> 5) * MEAS_RECIP) >> MEAS_SHIFT,
    // exact while n >> 5 stays below 2^28 (1737 * 2^28 < 2^39 * 1)
    localparam int                 MEAS_PRE_SHIFT = 5;
    localparam int                 RECIP_W        = 28;
    localparam int                 PROD_W         = 2 * RECIP_W;
    localparam logic [RECIP_W-1:0] MEAS_RECIP     = 28'd175921861;
    localparam int                 MEAS_SHIFT     = 39;

    // Gain divider produces 16 quotient bits, one per cycle
    localparam int DIV_STEPS = 16;

    localparam int CLAMP_W = 22;

    function automatic logic [15:0] clamp_q15(input logic signed [CLAMP_W-1:0] v);
        logic [15:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({6'b0, Q15_ONE})) begin
            res = Q15_ONE;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

// ----- design/pskf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pskf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/pskf_fifo.sv -----
// Short request queue between the front (measurement) and back (update) stages.
// No dependencies.
module pskf_fifo #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- design/pskf_front.sv -----
// Front stage: accepts input items, wraps the cell index and forms the fused
// measurement, dividing by 100000 with a reciprocal multiply. Depends on pskf_pkg.
module pskf_front #(
    parameter int CELL_COUNT = 256,
    parameter int IDX_W      = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pskf_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                           q_valid,
    input  logic                           q_ready,
    output logic [IDX_W-1:0]               q_idx,
    output pskf_pkg::meas_t                q_z
);
    import pskf_pkg::*;

    typedef enum logic [2:0] {F_IDLE, F_MUL_Q, F_MUL_D, F_DIV, F_PUSH} fstate_t;

    // Index modulo CELL_COUNT by shifted compare-subtract
    function automatic logic [7:0] wrap_index(input logic [7:0] raw);
        logic [24:0] rem;
        logic [24:0] lim;
        rem = {17'b0, raw};
        for (int s = 7; s >= 0; s--) begin
            lim = 25'(CELL_COUNT) << s;
            if (rem >= lim) begin
                rem = rem - lim;
            end
        end
        return rem[7:0];
    endfunction

    fstate_t          state_reg, state_next;
    logic [IDX_W-1:0] cell_reg, cell_next;
    logic [15:0]      qual_reg, qual_next;
    logic [15:0]      dem_reg, dem_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [15:0]      quo_reg, quo_next;

    logic [7:0]        wrapped;
    logic [PROD_W-1:0] recip_prod;

    assign s_tready = (state_reg == F_IDLE);
    assign q_valid  = (state_reg == F_PUSH);
    assign q_idx    = cell_reg;
    assign q_z      = $signed({1'b0, quo_reg}) - MEAS_BIAS;

    assign wrapped    = wrap_index(s_tdata[7:0]);
    assign recip_prod = PROD_W'(acc_reg[ACC_W-1:MEAS_PRE_SHIFT]) * PROD_W'(MEAS_RECIP);

    always_comb begin
        state_next = state_reg;
        cell_next  = cell_reg;
        qual_next  = qual_reg;
        dem_next   = dem_reg;
        acc_next   = acc_reg;
        quo_next   = quo_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_tvalid) begin
                    cell_next  = wrapped[IDX_W-1:0];
                    qual_next  = s_tdata[37:22];
                    dem_next   = s_tdata[53:38];
                    acc_next   = MEAS_OFFSET - ACC_W'(s_tdata[21:8]) * MOIST_GAIN;
                    state_next = F_MUL_Q;
                end
            end
            F_MUL_Q: begin
                acc_next   = acc_reg + ACC_W'(qual_reg) * QUAL_GAIN;
                state_next = F_MUL_D;
            end
            F_MUL_D: begin
                acc_next   = acc_reg + ACC_W'(dem_reg) * DEMAND_GAIN;
                state_next = F_DIV;
            end
            F_DIV: begin
                // divide by 100000 as a multiply by the scaled reciprocal
                quo_next   = recip_prod[MEAS_SHIFT +: 16];
                state_next = F_PUSH;
            end
            F_PUSH: begin
                if (q_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cell_reg <= cell_next;
        qual_reg <= qual_next;
        dem_reg  <= dem_next;
        acc_reg  <= acc_next;
        quo_reg  <= quo_next;
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/pskf_back.sv -----
// Back stage: per-cell state store, gain divider, Kalman update and result register.
// Depends on pskf_pkg and pskf_ram.
module pskf_back #(
    parameter int CELLS = 256,
    parameter int IDX_W = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  logic [IDX_W-1:0]                q_idx,
    input  pskf_pkg::meas_t                 q_z,
    input  logic [pskf_pkg::CFG_W-1:0]      process_variance,
    input  logic [pskf_pkg::CFG_W-1:0]      measurement_variance,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pskf_pkg::OUT_DATA_W-1:0] m_tdata
);
    import pskf_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE, B_READ, B_DIV, B_MULX, B_MULP, B_VAR, B_FIN
    } bstate_t;

    bstate_t                state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    meas_t                  z_reg, z_next;
    logic [15:0]            x_reg, x_next;
    logic [16:0]            p_reg, p_next;
    logic [17:0]            den_reg, den_next;
    logic                   den_zero_reg, den_zero_next;
    logic [17:0]            r_reg, r_next;
    logic [15:0]            k_reg, k_next;
    logic [3:0]             cnt_reg, cnt_next;
    logic signed [34:0]     prodx_reg, prodx_next;
    logic [33:0]            prodp_reg, prodp_next;
    logic [15:0]            xnew_reg, xnew_next;
    logic [15:0]            vnew_reg, vnew_next;
    logic [CELLS-1:0]       started_reg, started_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]  out_data_reg, out_data_next;

    logic                   ram_we;
    logic [31:0]            ram_rdata;

    logic [16:0]            p_sum;
    logic [17:0]            den_sum;
    logic [18:0]            div_t;
    logic                   div_bit;
    logic [15:0]            k_eff;
    logic signed [17:0]     diff;
    logic [16:0]            one_minus_k;
    logic signed [34:0]     adj;
    logic signed [CLAMP_W-1:0] xsum;
    logic [18:0]            vshift;

    pskf_ram #(
        .WIDTH (32),
        .DEPTH (CELLS),
        .AW    (IDX_W)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata ({vnew_reg, xnew_reg}),
        .raddr (q_idx),
        .rdata (ram_rdata)
    );

    assign q_ready  = (state_reg == B_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // datapath terms
    assign p_sum       = 17'(ram_rdata[31:16]) + 17'(process_variance);
    assign den_sum     = 18'(p_sum) + 18'(measurement_variance);
    assign div_t       = (cnt_reg == 4'(DIV_STEPS - 1)) ? {1'b0, r_reg} : {r_reg, 1'b0};
    assign div_bit     = (div_t >= {1'b0, den_reg});
    assign k_eff       = den_zero_reg ? '0 : k_reg;
    assign diff        = $signed({z_reg[MEAS_W-1], z_reg}) - $signed({2'b0, x_reg});
    assign one_minus_k = {1'b0, Q15_ONE} - {1'b0, k_reg};
    assign adj         = (prodx_reg + 35'sd16384) >>> 15;
    assign xsum        = $signed({6'b0, x_reg}) + adj[CLAMP_W-1:0];
    assign vshift      = prodp_reg[33:15];

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        z_next         = z_reg;
        x_next         = x_reg;
        p_next         = p_reg;
        den_next       = den_reg;
        den_zero_next  = den_zero_reg;
        r_next         = r_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        prodx_next     = prodx_reg;
        prodp_next     = prodp_reg;
        xnew_next      = xnew_reg;
        vnew_next      = vnew_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    idx_next   = q_idx;
                    z_next     = q_z;
                    state_next = B_READ;
                end
            end
            B_READ: begin
                x_next = ram_rdata[15:0];
                if (!started_reg[idx_reg]) begin
                    // first visit: take the measurement, clamped to 0..1
                    xnew_next  = clamp_q15(CLAMP_W'(z_reg));
                    vnew_next  = Q15_HALF;
                    state_next = B_FIN;
                end else begin
                    p_next        = p_sum;
                    den_next      = den_sum;
                    den_zero_next = (den_sum == '0);
                    r_next        = 18'(p_sum);
                    k_next        = '0;
                    cnt_next      = 4'(DIV_STEPS - 1);
                    state_next    = B_DIV;
                end
            end
            B_DIV: begin
                // K = P*2^15 / (P+R), one quotient bit per cycle
                r_next   = div_bit ? 18'(div_t - {1'b0, den_reg}) : div_t[17:0];
                k_next   = {k_reg[14:0], div_bit};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = B_MULX;
                end
            end
            B_MULX: begin
                k_next     = k_eff;
                prodx_next = $signed({1'b0, k_eff}) * diff;
                state_next = B_MULP;
            end
            B_MULP: begin
                prodp_next = 34'(one_minus_k) * 34'(p_reg);
                xnew_next  = clamp_q15(xsum);
                state_next = B_VAR;
            end
            B_VAR: begin
                vnew_next  = (vshift[18:16] != '0) ? 16'hFFFF : vshift[15:0];
                state_next = B_FIN;
            end
            B_FIN: begin
                if (!out_valid_reg || m_tready) begin
                    ram_we                = 1'b1;
                    started_next[idx_reg] = 1'b1;
                    out_valid_next        = 1'b1;
                    out_data_next         = {vnew_reg, xnew_reg};
                    state_next            = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        z_reg        <= z_next;
        x_reg        <= x_next;
        p_reg        <= p_next;
        den_reg      <= den_next;
        den_zero_reg <= den_zero_next;
        r_reg        <= r_next;
        k_reg        <= k_next;
        cnt_reg      <= cnt_next;
        prodx_reg    <= prodx_next;
        prodp_reg    <= prodp_next;
        xnew_reg     <= xnew_next;
        vnew_reg     <= vnew_next;
        out_data_reg <= out_data_next;
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            started_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- design/per_cell_scalar_kalman_fusion.sv -----
// Top level of the per-cell scalar Kalman fusion block: config registers,
// front stage, request queue and back stage. Depends on pskf_pkg and submodules.
//
// Usage
//   s_ channel: one request per sensor reading (cell, moisture, quality, demand).
//   m_ channel: one result per request, in request order (readiness, variance).
//   cfg port: cfg_we/cfg_addr/cfg_wdata write process_variance (0) and
//   measurement_variance (1); write only while the block is idle.
// Pipeline
//   Front: accept, multiply-accumulate of quality, then of demand, reciprocal
//   multiply, push; the divide by 100000 is a multiply by a scaled reciprocal.
//   Back: pop, RAM read, gain divide, the math steps (gain times innovation, new
//   state, new variance), write; it is paced by the bit-serial gain divider, and
//   a cell's first request skips the divide and the math. The stages overlap
//   through a two-entry queue; the back stage takes a new request only once the
//   last one is written, the front only once its own item has been pushed.
// Reset
//   aresetn (sync, active low) clears all cell "started" flags, the queue and
//   restores default noise variances; state RAM contents are left as is.
// Backpressure: one result is held in the output register; while it is not
//   taken the back stage holds its next result, the queue fills, then s_tready drops.
module per_cell_scalar_kalman_fusion #(
    parameter int CELL_COUNT = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // slave: cell_index[7:0], soil_moisture[21:8], water_quality[37:22],
    //        evapo_demand[53:38], zero pad [55:54]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pskf_pkg::IN_DATA_W-1:0]  s_tdata,
    // master: readiness_out[15:0], variance_out[31:16]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pskf_pkg::OUT_DATA_W-1:0] m_tdata,
    // config write port
    input  logic                            cfg_we,
    input  logic                            cfg_addr,
    input  logic [pskf_pkg::CFG_W-1:0]      cfg_wdata
);
    import pskf_pkg::*;

    // only indexes 0..255 are reachable, so storage stops there
    localparam int CELLS = (CELL_COUNT < 256) ? CELL_COUNT : 256;
    localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int Q_W   = IDX_W + MEAS_W;

    logic [CFG_W-1:0] pv_reg;
    logic [CFG_W-1:0] mv_reg;

    // front -> queue
    logic             f_valid, f_ready;
    logic [IDX_W-1:0] f_idx;
    meas_t            f_z;

    // queue -> back
    logic             b_valid, b_ready;
    logic [Q_W-1:0]   b_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= PROCESS_VAR_RST;
            mv_reg <= MEAS_VAR_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_PROCESS_VAR: pv_reg <= cfg_wdata;
                REG_MEAS_VAR:    mv_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    pskf_front #(
        .CELL_COUNT (CELL_COUNT),
        .IDX_W      (IDX_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_idx    (f_idx),
        .q_z      (f_z)
    );

    pskf_fifo #(
        .WIDTH (Q_W),
        .DEPTH (2)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_idx, f_z}),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    pskf_back #(
        .CELLS (CELLS),
        .IDX_W (IDX_W)
    ) u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .q_valid              (b_valid),
        .q_ready              (b_ready),
        .q_idx                (b_data[Q_W-1:MEAS_W]),
        .q_z                  (b_data[MEAS_W-1:0]),
        .process_variance     (pv_reg),
        .measurement_variance (mv_reg),
        .m_tvalid             (m_tvalid),
        .m_tready             (m_tready),
        .m_tdata              (m_tdata)
    );

endmodule

// ----- verif/per_cell_scalar_kalman_fusion_tb.sv -----
// Self-checking testbench for per_cell_scalar_kalman_fusion: an in-bench fixed-point
// predictor, a stream driver and a result monitor. Depends on pskf_pkg and the design.
module per_cell_scalar_kalman_fusion_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pskf_pkg::*;

    localparam int CELLS        = 256;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_ITEMS  = 150;
    localparam int NUM_PHASES   = 6;

    // One sensor request, packed exactly as s_tdata (first field in the low bits)
    typedef struct packed {
        logic [1:0]  pad;
        logic [15:0] evapo_demand;
        logic [15:0] water_quality;
        logic [13:0] soil_moisture;
        logic [7:0]  cell_index;
    } reading_t;

    typedef struct {
        logic [15:0] readiness;
        logic [15:0] variance;
    } estimate_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_addr  = REG_PROCESS_VAR;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    per_cell_scalar_kalman_fusion #(.CELL_COUNT(CELLS)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the per-cell filters and noise regs
    // ------------------------------------------------------------------
    logic [15:0] est_readiness [CELLS];
    logic [15:0] est_variance  [CELLS];
    logic        est_started   [CELLS];
    logic [15:0] q_noise = PROCESS_VAR_RST;   // process variance
    logic [15:0] r_noise = MEAS_VAR_RST;      // measurement variance

    reading_t  pending_readings [$];   // requests not yet offered
    estimate_t expected_estimates [$]; // predicted results, oldest first

    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct  = 0;            // chance per cycle the sender holds off
    int recv_stall_pct = 0;            // chance per cycle the receiver stalls

    // floor division for a positive divisor
    function automatic longint div_floor(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v < 0) return 0;
        if (v > 32768) return 32768;
        return v;
    endfunction

    // Fuse the three sensor readings, run the cell's filter, queue the estimate
    function automatic void predict_estimate(input reading_t r);
        longint    num, z, x, p, den, k, pv;
        int        cell_no;
        estimate_t e;
        cell_no = int'(r.cell_index) % CELLS;
        num = 64'sd163840 * (64'sd10000 - longint'(r.soil_moisture))
            + 64'sd30000 * longint'(r.water_quality)
            + 64'sd20000 * longint'(r.evapo_demand)
            + 64'sd50000;
        z = div_floor(num, 100000);
        if (!est_started[cell_no]) begin
            // first reading of a cell seeds the filter
            est_readiness[cell_no] = 16'(clamp_unit(z));
            est_variance[cell_no]  = 16'd16384;
            est_started[cell_no]   = 1'b1;
        end else begin
            p   = longint'(est_variance[cell_no]) + longint'(q_noise);
            den = p + longint'(r_noise);
            // zero denominator only with both noise terms and variance at zero
            k   = (den != 0) ? (p * 32768) / den : 0;
            x   = longint'(est_readiness[cell_no]);
            x   = x + div_floor(k * (z - x) + 16384, 32768);
            est_readiness[cell_no] = 16'(clamp_unit(x));
            pv  = ((32768 - k) * p) / 32768;
            if (pv > 65535) pv = 65535;
            est_variance[cell_no] = 16'(pv);
        end
        e.readiness = est_readiness[cell_no];
        e.variance  = est_variance[cell_no];
        expected_estimates.push_back(e);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("tb: %s mismatch at cycle %0d: got %0d, expected %0d",
                 what, cycle_count, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued requests, predicts each one as it is accepted
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_estimate(reading_t'(s_tdata));
            if (!s_tvalid || s_tready) begin
                // slot free: maybe load the next request, maybe idle a cycle
                if (pending_readings.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_DATA_W'(pending_readings.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random backpressure and field-by-field compare in order
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        estimate_t want;
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_estimates.size() == 0) begin
                report_mismatch("unexpected result, readiness", int'(m_tdata[15:0]), -1);
            end else begin
                want = expected_estimates.pop_front();
                if (m_tdata[15:0] !== want.readiness)
                    report_mismatch("readiness_out", int'(m_tdata[15:0]), int'(want.readiness));
                if (m_tdata[31:16] !== want.variance)
                    report_mismatch("variance_out", int'(m_tdata[31:16]), int'(want.variance));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_reading(input int cell_no, input int moist,
                                          input int qual, input int dem);
        reading_t r;
        r.pad           = '0;
        r.cell_index    = 8'(cell_no);
        r.soil_moisture = 14'(moist);
        r.water_quality = 16'(qual);
        r.evapo_demand  = 16'(dem);
        pending_readings.push_back(r);
    endfunction

    // Q1.15 index: mostly in range, sometimes an end point or the full field
    function automatic int pick_index();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5)  return ($urandom_range(1) != 0) ? 32768 : 0;
        if (sel < 13) return $urandom_range(65535);
        return $urandom_range(32768);
    endfunction

    // A few hot cells so most requests run the update path, the rest anywhere
    function automatic void queue_random_reading();
        int cell_no, moist;
        if ($urandom_range(99) < 70) cell_no = $urandom_range(7) * 37;
        else                          cell_no = $urandom_range(255);
        if ($urandom_range(99) < 85) moist = $urandom_range(10000);
        else                          moist = $urandom_range(16383);
        queue_reading(cell_no, moist, pick_index(), pick_index());
    endfunction

    // Let every request and result through, then wait out the pipeline
    task automatic drain();
        while (pending_readings.size() != 0 || s_tvalid || expected_estimates.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write both noise registers while the block is idle
    task automatic write_noise(input logic [15:0] q_val, input logic [15:0] r_val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_PROCESS_VAR;
        cfg_wdata <= q_val;
        @(posedge aclk);
        cfg_addr  <= REG_MEAS_VAR;
        cfg_wdata <= r_val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        q_noise = q_val;
        r_noise = r_val;
    endtask

    initial begin
        logic [15:0] q_val, r_val;
        for (int i = 0; i < CELLS; i++) begin
            est_started[i]   = 1'b0;
            est_readiness[i] = '0;
            est_variance[i]  = '0;
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, reset noise values, no idling
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_reading(0,   0,     0,     0);        // seed at mid scale
        queue_reading(0,   10000, 32768, 32768);    // update, full indices
        queue_reading(255, 16383, 0,     0);        // seed, wet soil drives z below 0
        queue_reading(255, 0,     32768, 32768);    // update toward 1.0
        queue_reading(1,   0,     65535, 65535);    // seed, z above 1.0 clamps high
        queue_reading(1,   0,     65535, 65535);
        queue_reading(1,   0,     65535, 65535);    // update clamp at the top
        queue_reading(1,   16383, 0,     0);
        queue_reading(1,   16383, 0,     0);
        queue_reading(1,   16383, 0,     0);        // update drives x below 0
        queue_reading(128, 10000, 0,     0);        // z rounds to zero
        queue_reading(128, 9999,  1,     1);
        queue_reading(170, 10922, 16'h5555, 16'hAAAA);
        queue_reading(85,  5461,  16'hAAAA, 16'h5555);
        queue_reading(0,   5000,  16384, 16384);
        queue_reading(0,   5000,  16384, 16384);
        queue_reading(0,   1,     32767, 1);        // same cell back to back
        drain();

        // No noise at all: gain goes to 1, variance to 0, then a zero denominator
        write_noise(16'd0, 16'd0);
        queue_reading(0, 2500, 8000, 20000);
        queue_reading(0, 7500, 30000, 100);
        queue_reading(0, 100,  100,   30000);
        queue_reading(2, 3000, 12000, 12000);       // seed of a fresh cell
        queue_reading(2, 9000, 1000,  32000);
        queue_reading(2, 9000, 1000,  32000);
        drain();

        // Random phases across noise settings and idling modes
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin q_val = PROCESS_VAR_RST; r_val = MEAS_VAR_RST;
                         send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin q_val = 16'd32768; r_val = 16'd1;
                         send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin q_val = 16'd0;     r_val = 16'd32768;
                         send_idle_pct = 0;  recv_stall_pct = 68; end
                3: begin q_val = 16'($urandom_range(32768));
                         r_val = 16'($urandom_range(32768, 1));
                         send_idle_pct = 18; recv_stall_pct = 18; end
                4: begin q_val = 16'd1;     r_val = 16'd1;
                         send_idle_pct = 68; recv_stall_pct = 0;  end
                default: begin q_val = 16'($urandom_range(32768));
                         r_val = 16'($urandom_range(32768, 1));
                         send_idle_pct = 0;  recv_stall_pct = 68; end
            endcase
            write_noise(q_val, r_val);
            for (int n = 0; n < PHASE_ITEMS; n++) queue_random_reading();
            drain();
        end

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/pskf_pkg.sv
design/pskf_ram.sv
design/pskf_fifo.sv
design/pskf_front.sv
design/pskf_back.sv
design/per_cell_scalar_kalman_fusion.sv
verif/per_cell_scalar_kalman_fusion_tb.sv
